FILE: hw/rtl/perspective_inverse_pixel_map_assert.svh
// assertion macros for the perspective inverse pixel map
// used by the top level; relies on clock and reset in the including scope
`ifndef PERSPECTIVE_INVERSE_PIXEL_MAP_ASSERT_SVH
`define PERSPECTIVE_INVERSE_PIXEL_MAP_ASSERT_SVH

// same-cycle implication
`define PIM_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("pim assertion failed");

// implication checked in the following cycle
`define PIM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("pim assertion failed");

`endif

FILE: hw/rtl/pim_pkg.sv
// shared constants and types for the perspective inverse pixel map
// no dependencies
`default_nettype none
package pim_pkg;
   localparam int COORD_BITS     = 12;
   localparam int COEF_FRAC_BITS = 16;
   localparam int W_FRAC_BITS    = 30;
   localparam int COEF_W         = 32;
   localparam int LIN_W          = 2 * COEF_W;
   localparam int DIM_W          = 13;
   localparam int INDEX_W        = 24;
   localparam int PROD_W         = COEF_W + COORD_BITS + 1;
   localparam int SUM_W          = PROD_W + 2;
   localparam int DIV_SHIFT      = W_FRAC_BITS - COEF_FRAC_BITS;
   localparam int QB             = DIM_W;
   localparam int DIV_W          = SUM_W + QB + DIV_SHIFT;
   localparam int CSR_IDX_W      = 4;
   localparam int CSR_DATA_W     = LIN_W;
   localparam int DOT_DEPTH      = 2;
   localparam int PIPE_DEPTH     = DOT_DEPTH + QB + 1;
   localparam int LATENCY        = PIPE_DEPTH + 2;

   localparam logic [LIN_W-1:0]  X_LIN_RESET = LIN_W'(1) << (COEF_W + COEF_FRAC_BITS);
   localparam logic [LIN_W-1:0]  Y_LIN_RESET = LIN_W'(1) << COEF_FRAC_BITS;
   localparam logic [COEF_W-1:0] W_OFF_RESET = COEF_W'(1) << W_FRAC_BITS;
   localparam logic [DIM_W-1:0]  DIM_RESET   = DIM_W'(4096);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_LIN  = 4'd0,
      CSR_X_OFF  = 4'd1,
      CSR_Y_LIN  = 4'd2,
      CSR_Y_OFF  = 4'd3,
      CSR_W_LIN  = 4'd4,
      CSR_W_OFF  = 4'd5,
      CSR_WIDTH  = 4'd6,
      CSR_HEIGHT = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic          ok;
      logic [QB-1:0] q;
   } div_res_type;
endpackage
`default_nettype wire

FILE: hw/rtl/perspective_inverse_pixel_map.sv
// channel   ports                          handshake
// request   start/busy, req_out_*          taken when start high and busy low
// response  rsp_valid, rsp_source_index..  one-cycle strobe, no back pressure
// csr       csr_valid/csr_ready, csr_*     write when valid and ready high
//
// one request per clock; each result passes through, in order,
// (2 dot-product stages, 1 divider setup, 13 quotient-bit stages, 2 index stages)
// the 13 quotient stages of the two dividers set the depth; busy stays low
// synchronous active-high reset clears the pipeline valids and loads the csr registers with defaults
// the receiver cannot stall, so the pipeline always advances
// depends on pim_pkg, pim_dot, pim_div and the assertion header
`default_nettype none
`include "perspective_inverse_pixel_map_assert.svh"
module perspective_inverse_pixel_map import pim_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire  [COORD_BITS-1:0]  req_out_column,
   input  wire  [COORD_BITS-1:0]  req_out_row,
   output logic                   rsp_valid,
   output logic [INDEX_W-1:0]     rsp_source_index,
   output logic                   rsp_in_range,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);
   logic [LIN_W-1:0]  x_lin_ff, y_lin_ff, w_lin_ff;
   logic [COEF_W-1:0] x_off_ff, y_off_ff, w_off_ff;
   logic [DIM_W-1:0]  width_ff, height_ff;

   logic                     accept;
   logic [PIPE_DEPTH-1:0]    vld_ff;
   logic signed [SUM_W-1:0]  nx, ny, dw;
   div_res_type              rx, ry;

   logic                  ok_in, ok_ff, va_ff;
   logic [2*DIM_W-1:0]    prod_in, prod_ff;
   logic [QB-1:0]         qx_ff;
   logic                  rsp_valid_ff, rsp_in_range_ff;
   logic [INDEX_W-1:0]    rsp_index_in, rsp_index_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_lin_ff  <= X_LIN_RESET;
         x_off_ff  <= '0;
         y_lin_ff  <= Y_LIN_RESET;
         y_off_ff  <= '0;
         w_lin_ff  <= '0;
         w_off_ff  <= W_OFF_RESET;
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_LIN:  x_lin_ff  <= csr_data;
            CSR_X_OFF:  x_off_ff  <= csr_data[COEF_W-1:0];
            CSR_Y_LIN:  y_lin_ff  <= csr_data;
            CSR_Y_OFF:  y_off_ff  <= csr_data[COEF_W-1:0];
            CSR_W_LIN:  w_lin_ff  <= csr_data;
            CSR_W_OFF:  w_off_ff  <= csr_data[COEF_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   pim_dot u_dot_x (.clock(clock), .lin(x_lin_ff), .off(x_off_ff),
                    .col(req_out_column), .row(req_out_row), .sum(nx));
   pim_dot u_dot_y (.clock(clock), .lin(y_lin_ff), .off(y_off_ff),
                    .col(req_out_column), .row(req_out_row), .sum(ny));
   pim_dot u_dot_w (.clock(clock), .lin(w_lin_ff), .off(w_off_ff),
                    .col(req_out_column), .row(req_out_row), .sum(dw));

   pim_div u_div_x (.clock(clock), .num(nx), .den(dw), .res(rx));
   pim_div u_div_y (.clock(clock), .num(ny), .den(dw), .res(ry));

   assign ok_in   = rx.ok && ry.ok && (rx.q < width_ff) && (ry.q < height_ff);
   assign prod_in = (2*DIM_W)'(ry.q) * (2*DIM_W)'(width_ff);
   assign rsp_index_in = ok_ff ? INDEX_W'(prod_ff + (2*DIM_W)'(qx_ff)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         va_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], accept};
         va_ff        <= vld_ff[PIPE_DEPTH-1];
         rsp_valid_ff <= va_ff;
      end
      ok_ff           <= ok_in;
      prod_ff         <= prod_in;
      qx_ff           <= rx.q;
      rsp_index_ff    <= rsp_index_in;
      rsp_in_range_ff <= ok_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_source_index = rsp_index_ff;
   assign rsp_in_range     = rsp_in_range_ff;

   `PIM_ASSERT_NOW(a_black_is_zero, rsp_valid && !rsp_in_range, rsp_source_index == '0)
   `PIM_ASSERT_NOW(a_rsp_has_req, rsp_valid, $past(accept, LATENCY))
   `PIM_ASSERT_NEXT(a_req_enters, accept, vld_ff[0])
endmodule
`default_nettype wire

FILE: hw/rtl/pim_dot.sv
// one row of the homography: two products and an offset, two register stages
// depends on pim_pkg
`default_nettype none
module pim_dot import pim_pkg::*; (
   input  wire                          clock,
   input  wire        [LIN_W-1:0]       lin,
   input  wire        [COEF_W-1:0]      off,
   input  wire        [COORD_BITS-1:0]  col,
   input  wire        [COORD_BITS-1:0]  row,
   output logic signed [SUM_W-1:0]      sum
);
   logic signed [COEF_W-1:0]     cc, rc;
   logic signed [COORD_BITS:0]   col_s, row_s;
   logic signed [PROD_W-1:0]     pc_in, pr_in, pc_ff, pr_ff;
   logic signed [COEF_W-1:0]     off_ff;
   logic signed [SUM_W-1:0]      sum_in, sum_ff;

   assign cc    = $signed(lin[LIN_W-1:COEF_W]);
   assign rc    = $signed(lin[COEF_W-1:0]);
   assign col_s = $signed({1'b0, col});
   assign row_s = $signed({1'b0, row});
   assign pc_in = PROD_W'(cc * col_s);
   assign pr_in = PROD_W'(rc * row_s);
   assign sum_in = SUM_W'(pc_ff) + SUM_W'(pr_ff) + SUM_W'(off_ff);

   always_ff @(posedge clock) begin
      pc_ff  <= pc_in;
      pr_ff  <= pr_in;
      off_ff <= $signed(off);
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/pim_div.sv
// pipelined restoring divider: truncated |num|*2^shift/|den|, one quotient bit a stage
// depends on pim_pkg
`default_nettype none
module pim_div import pim_pkg::*; (
   input  wire                     clock,
   input  wire signed [SUM_W-1:0]  num,
   input  wire signed [SUM_W-1:0]  den,
   output div_res_type             res
);
   logic [SUM_W-1:0]  n_abs, d_abs;
   logic [DIV_W-1:0]  x_in;
   logic              neg_in, bad_in;

   logic [DIV_W-1:0]  rem_ff [0:QB];
   logic [QB-1:0]     quo_ff [0:QB];
   logic [SUM_W-1:0]  den_ff [0:QB];
   logic              neg_ff [0:QB];
   logic              bad_ff [0:QB];

   assign n_abs  = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
   assign d_abs  = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
   assign neg_in = num[SUM_W-1] ^ den[SUM_W-1];
   assign x_in   = DIV_W'(n_abs) << DIV_SHIFT;
   // quotient too big for the dimension range, or zero denominator
   assign bad_in = (d_abs == '0) || (x_in >= (DIV_W'(d_abs) << QB));

   always_ff @(posedge clock) begin
      rem_ff[0] <= x_in;
      quo_ff[0] <= '0;
      den_ff[0] <= d_abs;
      neg_ff[0] <= neg_in;
      bad_ff[0] <= bad_in;
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int B = QB - 1 - k;
      logic [DIV_W-1:0] trial;
      logic             ge;
      assign trial = DIV_W'(den_ff[k]) << B;
      assign ge    = rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? rem_ff[k] - trial : rem_ff[k];
         quo_ff[k+1] <= quo_ff[k] | (QB'(ge) << B);
         den_ff[k+1] <= den_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         bad_ff[k+1] <= bad_ff[k];
      end
   end

   // a negative value that truncates to zero still counts as zero
   assign res.ok = !bad_ff[QB] && !(neg_ff[QB] && (quo_ff[QB] != '0));
   assign res.q  = quo_ff[QB];
endmodule
`default_nettype wire
